// File: rtl/core/urtt_pkg.sv
package urtt_pkg;

  localparam int COUNT_WIDTH_DEF = 20;

  localparam int TRIG_W = 10;
  localparam int TMO_W  = 20;
  localparam int MM_W   = 16;
  localparam int Q16_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MM_PER_TICK   = 2'd3;

  localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 10'd10;
  localparam logic [TMO_W-1:0]  TIMEOUT_TICKS_RST = 20'd100000;
  localparam logic [MM_W-1:0]   FAR_THRESHOLD_RST = 16'd1000;
  localparam logic [Q16_W-1:0]  MM_PER_TICK_RST   = 16'd11239;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TMO_HIGH = 2'd1;
  localparam logic [1:0] ST_TMO_LOW  = 2'd2;

  localparam logic [2:0] TURNS_RST = 3'd3;
  localparam logic [2:0] TURNS_MAX = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_TRIG  = 4'b0010,
    PH_WHIGH = 4'b0100,
    PH_WLOW  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TRIG_W-1:0] trigger_ticks;
    logic [TMO_W-1:0]  timeout_ticks;
    logic [MM_W-1:0]   far_threshold_mm;
    logic [Q16_W-1:0]  mm_per_tick_q16;
  } cfg_t;

  typedef struct packed {
    logic cmd;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic            trigger_out;
    logic            busy_res;
    logic            done_res;
    logic [1:0]      status;
    logic [MM_W-1:0] distance_mm;
    logic            turn_event;
    logic [2:0]      turn_count;
  } res_t;

endpackage

// File: rtl/core/urtt_cfg_regs.sv
module urtt_cfg_regs
  import urtt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks    <= TRIGGER_TICKS_RST;
      cfg_r.timeout_ticks    <= TIMEOUT_TICKS_RST;
      cfg_r.far_threshold_mm <= FAR_THRESHOLD_RST;
      cfg_r.mm_per_tick_q16  <= MM_PER_TICK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_TICKS: cfg_r.trigger_ticks    <= cfg_data[TRIG_W-1:0];
        REG_TIMEOUT_TICKS: cfg_r.timeout_ticks    <= cfg_data[TMO_W-1:0];
        REG_FAR_THRESHOLD: cfg_r.far_threshold_mm <= cfg_data[MM_W-1:0];
        REG_MM_PER_TICK:   cfg_r.mm_per_tick_q16  <= cfg_data[Q16_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/urtt_in_stage.sv
module urtt_in_stage
  import urtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     adv,
  output logic     s1_valid,
  output in_item_t s1_item
);

  logic     valid_r;
  in_item_t item_r;

  assign in_stall = valid_r & ~adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// File: rtl/core/urtt_ranger.sv
module urtt_ranger
  import urtt_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     step,
  input  in_item_t item,
  output res_t     res
);

  localparam int CMP_W  = (COUNT_WIDTH > TMO_W) ? COUNT_WIDTH : TMO_W;
  localparam int PROD_W = COUNT_WIDTH + Q16_W;
  localparam int EXT_W  = (PROD_W > 32) ? PROD_W : 32;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32'h0000_8000);

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] wait_r, wait_nxt;
  logic [COUNT_WIDTH-1:0] high_r, high_nxt;
  logic                   hold_r, hold_nxt;
  logic [2:0]             turns_r, turns_nxt;

  logic [COUNT_WIDTH-1:0] wait_inc;
  logic [CMP_W-1:0]       trig_cmp;
  logic [CMP_W-1:0]       tmo_cmp;
  logic [CMP_W-1:0]       wait_inc_cmp;
  logic [CMP_W-1:0]       one_cmp;
  logic [PROD_W-1:0]      prod;
  logic [EXT_W-1:0]       mm_ext;
  logic [MM_W-1:0]        dist_sat;
  logic                   far;

  assign wait_inc     = (&wait_r) ? wait_r : wait_r + COUNT_WIDTH'(1);
  assign trig_cmp     = CMP_W'(cfg.trigger_ticks);
  assign tmo_cmp      = CMP_W'(cfg.timeout_ticks);
  assign wait_inc_cmp = CMP_W'(wait_inc);
  assign one_cmp      = CMP_W'(1);

  // high count * q16 plus the rounding half
  assign prod     = PROD_W'(high_r) * PROD_W'(cfg.mm_per_tick_q16) + ROUND_HALF;
  assign mm_ext   = EXT_W'(prod) >> 16;
  assign dist_sat = (|mm_ext[EXT_W-1:16]) ? {MM_W{1'b1}} : mm_ext[MM_W-1:0];
  assign far      = dist_sat > cfg.far_threshold_mm;

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    high_nxt  = high_r;
    hold_nxt  = hold_r;
    turns_nxt = turns_r;
    res       = '0;
    case (phase_r)
      PH_IDLE: begin
        if (item.cmd) begin
          res.trigger_out = 1'b1;
          if (one_cmp >= trig_cmp) begin
            phase_nxt = PH_WHIGH;
            wait_nxt  = '0;
          end else begin
            phase_nxt = PH_TRIG;
            wait_nxt  = COUNT_WIDTH'(1);
          end
        end
      end
      PH_TRIG: begin
        res.trigger_out = 1'b1;
        if (wait_inc_cmp >= trig_cmp) begin
          phase_nxt = PH_WHIGH;
          wait_nxt  = '0;
        end else begin
          wait_nxt = wait_inc;
        end
      end
      PH_WHIGH: begin
        if (item.echo_level) begin
          phase_nxt = PH_WLOW;
          high_nxt  = COUNT_WIDTH'(1);
          wait_nxt  = COUNT_WIDTH'(1);
          if (one_cmp >= tmo_cmp) begin
            res.done_res = 1'b1;
            res.status   = ST_TMO_LOW;
            phase_nxt    = PH_IDLE;
          end
        end else begin
          wait_nxt = wait_inc;
          if (wait_inc_cmp >= tmo_cmp) begin
            res.done_res = 1'b1;
            res.status   = ST_TMO_HIGH;
            phase_nxt    = PH_IDLE;
          end
        end
      end
      PH_WLOW: begin
        if (!item.echo_level) begin
          res.done_res    = 1'b1;
          res.status      = ST_OK;
          res.distance_mm = dist_sat;
          phase_nxt       = PH_IDLE;
          if (far && !hold_r) begin
            res.turn_event = 1'b1;
            turns_nxt      = (turns_r >= TURNS_MAX) ? 3'd0 : turns_r + 3'd1;
          end
          hold_nxt = far;
        end else begin
          if (!(&high_r)) begin
            high_nxt = high_r + COUNT_WIDTH'(1);
          end
          wait_nxt = wait_inc;
          if (wait_inc_cmp >= tmo_cmp) begin
            res.done_res = 1'b1;
            res.status   = ST_TMO_LOW;
            phase_nxt    = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.turn_count = turns_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= '0;
      high_r  <= '0;
      hold_r  <= 1'b0;
      turns_r <= TURNS_RST;
    end else if (step) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      high_r  <= high_nxt;
      hold_r  <= hold_nxt;
      turns_r <= turns_nxt;
    end
  end

endmodule

// File: rtl/core/urtt_out_stage.sv
module urtt_out_stage
  import urtt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic s1_valid,
  input  res_t res,
  output logic adv,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic valid_r;
  res_t res_r;

  assign adv = ~valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: rtl/core/ultrasonic_ranger_turn_trigger_top.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | in_cmd, in_echo_level
// out     | output    | out_valid / out_stall  | out_trigger_out .. out_turn_count
// cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low. A request taken sits in the input
// register; its result is loaded into the result register and leaves from there.
// Distance is high count times mm_per_tick_q16, rounded, at the falling echo edge.
// Synchronous active-low reset; config returns to defaults, no clear sweep.
// out_stall holds the result register and backs up into in_stall.
module ultrasonic_ranger_turn_trigger_top
  import urtt_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic                  in_echo_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_trigger_out,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic [1:0]            out_status,
  output logic [MM_W-1:0]       out_distance_mm,
  output logic                  out_turn_event,
  output logic [2:0]            out_turn_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t s1_item;
  logic     s1_valid;
  logic     adv;
  res_t     res;
  res_t     out_res;

  assign in_item.cmd        = in_cmd;
  assign in_item.echo_level = in_echo_level;

  urtt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  urtt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  urtt_ranger #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ranger (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (adv & s1_valid),
    .item  (s1_item),
    .res   (res)
  );

  urtt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_trigger_out = out_res.trigger_out;
  assign out_busy_res    = out_res.busy_res;
  assign out_done_res    = out_res.done_res;
  assign out_status      = out_res.status;
  assign out_distance_mm = out_res.distance_mm;
  assign out_turn_event  = out_res.turn_event;
  assign out_turn_count  = out_res.turn_count;

endmodule

// File: tb/ranger_check.sv
`timescale 1ns / 1ps
module ranger_check
  import urtt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_cmd,
  input  logic                  in_echo_level,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_trigger_out,
  input  logic                  out_busy_res,
  input  logic                  out_done_res,
  input  logic [1:0]            out_status,
  input  logic [MM_W-1:0]       out_distance_mm,
  input  logic                  out_turn_event,
  input  logic [2:0]            out_turn_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  localparam int CW = COUNT_WIDTH_DEF;

  cfg_t          regs;
  phase_t        ph;
  logic [CW-1:0] wait_cnt;
  logic [CW-1:0] high_cnt;
  logic          far_hold;
  logic [2:0]    turns;
  res_t          tick_results_q[$];
  int            bad;

  function automatic logic [CW-1:0] sat_up(logic [CW-1:0] v);
    return (v == '1) ? v : v + CW'(1);
  endfunction

  function automatic string show(res_t r);
    return $sformatf("trig=%0d busy=%0d done=%0d status=%0d dist=%0d turn=%0d count=%0d",
                     r.trigger_out, r.busy_res, r.done_res, r.status, r.distance_mm,
                     r.turn_event, r.turn_count);
  endfunction

  // one tick of the ranger: advances the predicted state, returns the tick's result
  function automatic res_t range_tick(logic cmd, logic echo);
    res_t        r;
    logic [63:0] mm;
    logic        far_hit;
    r = '0;
    case (ph)
      PH_IDLE: begin
        if (cmd) begin
          r.trigger_out = 1'b1;
          wait_cnt = CW'(1);
          if (wait_cnt >= regs.trigger_ticks) begin
            ph = PH_WHIGH;
            wait_cnt = '0;
          end else begin
            ph = PH_TRIG;
          end
        end
      end
      PH_TRIG: begin
        r.trigger_out = 1'b1;
        wait_cnt = sat_up(wait_cnt);
        if (wait_cnt >= regs.trigger_ticks) begin
          ph = PH_WHIGH;
          wait_cnt = '0;
        end
      end
      PH_WHIGH: begin
        if (echo) begin
          ph = PH_WLOW;
          high_cnt = CW'(1);
          wait_cnt = CW'(1);
          if (wait_cnt >= regs.timeout_ticks) begin
            r.done_res = 1'b1;
            r.status = ST_TMO_LOW;
            ph = PH_IDLE;
          end
        end else begin
          wait_cnt = sat_up(wait_cnt);
          if (wait_cnt >= regs.timeout_ticks) begin
            r.done_res = 1'b1;
            r.status = ST_TMO_HIGH;
            ph = PH_IDLE;
          end
        end
      end
      default: begin
        if (!echo) begin
          mm = (64'(high_cnt) * 64'(regs.mm_per_tick_q16) + 64'd32768) >> 16;
          r.distance_mm = (mm > 64'd65535) ? 16'hFFFF : mm[15:0];
          r.done_res = 1'b1;
          r.status = ST_OK;
          ph = PH_IDLE;
          far_hit = r.distance_mm > regs.far_threshold_mm;
          if (far_hit && !far_hold) begin
            r.turn_event = 1'b1;
            turns = (turns >= TURNS_MAX) ? 3'd0 : turns + 3'd1;
          end
          far_hold = far_hit;
        end else begin
          high_cnt = sat_up(high_cnt);
          wait_cnt = sat_up(wait_cnt);
          if (wait_cnt >= regs.timeout_ticks) begin
            r.done_res = 1'b1;
            r.status = ST_TMO_LOW;
            ph = PH_IDLE;
          end
        end
      end
    endcase
    r.busy_res = (ph != PH_IDLE);
    r.turn_count = turns;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      regs = '{TRIGGER_TICKS_RST, TIMEOUT_TICKS_RST, FAR_THRESHOLD_RST, MM_PER_TICK_RST};
      ph = PH_IDLE;
      wait_cnt = '0;
      high_cnt = '0;
      far_hold = 1'b0;
      turns = TURNS_RST;
      tick_results_q.delete();
      bad = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TRIGGER_TICKS: regs.trigger_ticks = cfg_data[TRIG_W-1:0];
          REG_TIMEOUT_TICKS: regs.timeout_ticks = cfg_data[TMO_W-1:0];
          REG_FAR_THRESHOLD: regs.far_threshold_mm = cfg_data[MM_W-1:0];
          REG_MM_PER_TICK:   regs.mm_per_tick_q16 = cfg_data[Q16_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.trigger_out = out_trigger_out;
        got.busy_res    = out_busy_res;
        got.done_res    = out_done_res;
        got.status      = out_status;
        got.distance_mm = out_distance_mm;
        got.turn_event  = out_turn_event;
        got.turn_count  = out_turn_count;
        if (tick_results_q.size() == 0) begin
          bad++;
          if (bad <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = tick_results_q.pop_front();
          if (got !== want) begin
            bad++;
            if (bad <= 10) $display("mismatch: expected %s, got %s", show(want), show(got));
          end
        end
      end
      if (in_valid && !in_stall) tick_results_q.push_back(range_tick(in_cmd, in_echo_level));
    end
    mismatches <= bad;
    pending <= tick_results_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import urtt_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_cmd = 1'b0;
  logic                  in_echo_level = 1'b0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TRIGGER_TICKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic            in_stall;
  logic            out_valid;
  logic            out_trigger_out;
  logic            out_busy_res;
  logic            out_done_res;
  logic [1:0]      out_status;
  logic [MM_W-1:0] out_distance_mm;
  logic            out_turn_event;
  logic [2:0]      out_turn_count;

  int mismatches;
  int pending;
  int send_pct = 0;
  int stall_pct = 0;
  int cur_trig = 10;
  int cur_tmo = 100000;
  int sent = 0;
  int quiet = 0;

  always #10 clk = ~clk;

  ultrasonic_ranger_turn_trigger_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_echo_level(in_echo_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_trigger_out(out_trigger_out), .out_busy_res(out_busy_res),
    .out_done_res(out_done_res), .out_status(out_status),
    .out_distance_mm(out_distance_mm), .out_turn_event(out_turn_event),
    .out_turn_count(out_turn_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ranger_check u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_echo_level(in_echo_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_trigger_out(out_trigger_out), .out_busy_res(out_busy_res),
    .out_done_res(out_done_res), .out_status(out_status),
    .out_distance_mm(out_distance_mm), .out_turn_event(out_turn_event),
    .out_turn_count(out_turn_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= 2000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic logic [CFG_DATA_W-1:0] pad(int v, int w);
    logic [CFG_DATA_W-1:0] m;
    m = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
    return (CFG_DATA_W'($urandom()) & ~m) | (CFG_DATA_W'(v) & m);
  endfunction

  task automatic push(input logic c, input logic e);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_echo_level <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // unused upper data bits are randomized; the block must mask them
  task automatic setup(int trig, int tmo, int far_mm, int q16);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_TRIGGER_TICKS;
    cfg_data <= pad(trig, TRIG_W);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data <= pad(tmo, TMO_W);
    @(posedge clk);
    cfg_index <= REG_FAR_THRESHOLD;
    cfg_data <= pad(far_mm, MM_W);
    @(posedge clk);
    cfg_index <= REG_MM_PER_TICK;
    cfg_data <= pad(q16, Q16_W);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_trig = trig;
    cur_tmo = tmo;
  endtask

  // one well-formed ranging request: trigger, low wait, high time, falling edge
  task automatic measure(int hmax, int fixed_h);
    int eff;
    int kmax;
    int k;
    int h;
    eff = (cur_trig == 0) ? 1 : cur_trig;
    kmax = (cur_tmo <= 1) ? 0 : ((cur_tmo - 1 < 8) ? cur_tmo - 1 : 8);
    k = (cur_tmo <= 5000 && $urandom_range(99) < 12) ? cur_tmo : $urandom_range(kmax);
    if (fixed_h > 0) begin
      h = fixed_h;
    end else if (cur_tmo <= 5000 && $urandom_range(99) < 12) begin
      h = (cur_tmo == 0) ? 1 : cur_tmo;
    end else begin
      h = $urandom_range((cur_tmo <= 1) ? 1 : ((cur_tmo - 1 < hmax) ? cur_tmo - 1 : hmax), 1);
    end
    push(1'b1, 1'($urandom_range(1)));
    repeat (eff - 1) push(1'($urandom_range(9) == 0), 1'($urandom_range(1)));
    repeat (k) push(1'($urandom_range(9) == 0), 1'b0);
    repeat (h) push(1'($urandom_range(9) == 0), 1'b1);
    push(1'($urandom_range(2) == 0), 1'b0);
  endtask

  task automatic burst(int target, int hmax);
    int start;
    int pick;
    start = sent;
    while (sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        repeat ($urandom_range(4, 1)) push(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 15) begin
        drain();
      end else begin
        measure(hmax, 0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_pct = 7;
    stall_pct = 56;

    // default settings: start while busy, short ok reading, start on the final tick
    push(1'b1, 1'b1);
    repeat (9) push(1'b1, 1'b1);
    push(1'b0, 1'b0);
    repeat (3) push(1'b0, 1'b1);
    push(1'b1, 1'b0);
    push(1'b0, 1'b0);
    // zero trigger length, timeout of one tick on each wait
    setup(0, 1, 0, 65535);
    push(1'b1, 1'b0);
    push(1'b0, 1'b0);
    push(1'b1, 1'b1);
    push(1'b0, 1'b1);
    push(1'b0, 1'b0);

    setup(1, 40, 0, 65535);
    burst(200, 40);
    setup(5, 60, 20, 65535);
    burst(200, 50);

    send_pct = 56;
    stall_pct = 7;
    setup(200, 50, 65535, 0);
    burst(300, 40);
    setup(3, 30, 4, 20000);
    burst(200, 30);

    send_pct = 0;
    stall_pct = 0;
    setup(2, 1048575, 65534, 65535);
    burst(100, 40);
    setup(0, 0, 50, 40000);
    burst(100, 10);
    setup(7, 25, 10, 65535);
    burst(200, 25);

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
